>>> hdl/bsc_pkg.sv
// Package for the barometric sensor compensation block.
// Holds the sequencer types, field widths and shift helpers; no dependencies.
`default_nettype none
package bsc_pkg;
	localparam int RawW    = 20;
	localparam int CalW    = 48;
	localparam int CfgIdxW = 8;
	localparam int WordW   = 32;
	localparam int CntW    = 5;

	localparam logic [CfgIdxW-1:0] RegTemp   = 8'd0;
	localparam logic [CfgIdxW-1:0] RegPressA = 8'd1;
	localparam logic [CfgIdxW-1:0] RegPressB = 8'd2;
	localparam logic [CfgIdxW-1:0] RegPressC = 8'd3;

	localparam logic [WordW-1:0] FineOffset = 32'd64000;
	localparam logic [WordW-1:0] AdcSpan    = 32'd1048576;
	localparam logic [WordW-1:0] PressScale = 32'd3125;
	localparam logic [WordW-1:0] DivBias    = 32'd32768;
	localparam logic [WordW-1:0] RoundHalf  = 32'd128;
	localparam logic [WordW-1:0] TempScale  = 32'd5;

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_MUL, S_POST, S_DIV, S_DIVPOST, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		ST_T0, ST_T1, ST_T2, ST_T3,
		ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9
	} step_t;

	function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] x,
		input logic [CntW-1:0] s);
		asr = $unsigned($signed(x) >>> s);
	endfunction

	function automatic logic [WordW-1:0] sx16(input logic [15:0] w);
		sx16 = {{16{w[15]}}, w};
	endfunction
endpackage
`default_nettype wire

>>> hdl/bsc_sample_if.sv
// Input channel of the compensation block: one raw converter reading per item.
// Depends on bsc_pkg for widths.
`default_nettype none
interface bsc_sample_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [bsc_pkg::RawW-1:0]  raw_sample;
	modport source (output valid, kind, raw_sample, input ready);
	modport sink (input valid, kind, raw_sample, output ready);
endinterface
`default_nettype wire

>>> hdl/bsc_result_if.sv
// Output channel of the compensation block: one compensated result per item.
// Depends on bsc_pkg for widths.
`default_nettype none
interface bsc_result_if;
	logic                              valid;
	logic                              ready;
	logic                              result_kind;
	logic signed [bsc_pkg::WordW-1:0]  temperature_centi;
	logic [bsc_pkg::WordW-1:0]         pressure_pa;
	logic                              zero_divisor;
	modport source (output valid, result_kind, temperature_centi, pressure_pa,
		zero_divisor, input ready);
	modport sink (input valid, result_kind, temperature_centi, pressure_pa,
		zero_divisor, output ready);
endinterface
`default_nettype wire

>>> hdl/barometric_sensor_compensation.sv
// Flow: a temperature item is a run of multiplies, a pressure item a run of multiplies and a
// divide; a sample is taken in idle and its result presented from S_OUT; a zero divisor ends after 6 multiplies.
// Throughput: one item at a time; set by the shared bit-serial 32x32 multiplier and the
// restoring divider, one bit per cycle each. The next item is taken while a result waits.
// Reset: calibration registers and the fine temperature clear to zero, no clearing pass.
// Depends on bsc_pkg, bsc_sample_if, bsc_result_if.
`default_nettype none
module barometric_sensor_compensation (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bsc_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [bsc_pkg::CalW-1:0]      cfg_data,
	bsc_sample_if.sink                         sample,
	bsc_result_if.source                       result
);
	localparam int W = bsc_pkg::WordW;

	bsc_pkg::state_t state_q, state_d;
	bsc_pkg::step_t  step_q;

	logic [bsc_pkg::CalW-1:0] cal0_q, cal1_q, cal2_q, cal3_q;
	logic [W-1:0] ft_q, v1_q, v2_q, q_q, p_q, fin_q;
	logic [W-1:0] ma_q, mb_q, acc_q, num_q, rem_q;
	logic [bsc_pkg::RawW-1:0] adc_q;
	logic [bsc_pkg::CntW-1:0] cnt_q;
	logic kind_q, zero_q;
	logic ovld_q, okind_q, ozero_q;
	logic [W-1:0] otemp_q, opress_q;

	logic [W-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, adc, d, vv, h;
	logic [W-1:0] opa, opb, v1n;
	logic [W+1:0] trial;
	logic         take, out_free, last;

	assign t1  = {16'd0, cal0_q[15:0]};
	assign t2  = bsc_pkg::sx16(cal0_q[31:16]);
	assign t3  = bsc_pkg::sx16(cal0_q[47:32]);
	assign p1  = {16'd0, cal1_q[15:0]};
	assign p2  = bsc_pkg::sx16(cal1_q[31:16]);
	assign p3  = bsc_pkg::sx16(cal1_q[47:32]);
	assign p4  = bsc_pkg::sx16(cal2_q[15:0]);
	assign p5  = bsc_pkg::sx16(cal2_q[31:16]);
	assign p6  = bsc_pkg::sx16(cal2_q[47:32]);
	assign p7  = bsc_pkg::sx16(cal3_q[15:0]);
	assign p8  = bsc_pkg::sx16(cal3_q[31:16]);
	assign p9  = bsc_pkg::sx16(cal3_q[47:32]);
	assign adc = {{(W - bsc_pkg::RawW){1'b0}}, adc_q};
	assign d   = (adc >> 4) - t1;
	assign vv  = bsc_pkg::asr(ft_q, 5'd1) - bsc_pkg::FineOffset;
	assign h   = bsc_pkg::asr(vv, 5'd2);
	assign v1n = bsc_pkg::asr(acc_q, 5'd15);

	assign trial    = {1'b0, rem_q, num_q[W-1]} - {2'b00, v1_q};
	assign take     = sample.valid && sample.ready;
	assign out_free = !ovld_q || result.ready;
	assign last     = (cnt_q == bsc_pkg::CntW'(W - 1));

	assign sample.ready = (state_q == bsc_pkg::S_IDLE);
	assign result.valid             = ovld_q;
	assign result.result_kind       = okind_q;
	assign result.temperature_centi = $signed(otemp_q);
	assign result.pressure_pa       = opress_q;
	assign result.zero_divisor      = ozero_q;

	always_comb begin
		opa = '0;
		opb = '0;
		case (step_q)
			bsc_pkg::ST_T0: begin opa = (adc >> 3) - (t1 << 1); opb = t2; end
			bsc_pkg::ST_T1: begin opa = d; opb = d; end
			bsc_pkg::ST_T2: begin opa = q_q; opb = t3; end
			bsc_pkg::ST_T3: begin opa = ft_q; opb = bsc_pkg::TempScale; end
			bsc_pkg::ST_P0: begin opa = h; opb = h; end
			bsc_pkg::ST_P1: begin opa = bsc_pkg::asr(q_q, 5'd11); opb = p6; end
			bsc_pkg::ST_P2: begin opa = v1_q; opb = p5; end
			bsc_pkg::ST_P3: begin opa = p3; opb = bsc_pkg::asr(q_q, 5'd13); end
			bsc_pkg::ST_P4: begin opa = p2; opb = v1_q; end
			bsc_pkg::ST_P5: begin opa = bsc_pkg::DivBias + v1_q; opb = p1; end
			bsc_pkg::ST_P6: begin
				opa = (bsc_pkg::AdcSpan - adc) - bsc_pkg::asr(v2_q, 5'd12);
				opb = bsc_pkg::PressScale;
			end
			bsc_pkg::ST_P7: begin opa = p_q >> 3; opb = p_q >> 3; end
			bsc_pkg::ST_P8: begin opa = p9; opb = q_q; end
			bsc_pkg::ST_P9: begin opa = p_q >> 2; opb = p8; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bsc_pkg::S_IDLE: if (take) state_d = bsc_pkg::S_LOAD;
			bsc_pkg::S_LOAD: state_d = bsc_pkg::S_MUL;
			bsc_pkg::S_MUL: if (last) state_d = bsc_pkg::S_POST;
			bsc_pkg::S_POST: begin
				if (step_q == bsc_pkg::ST_T3 || step_q == bsc_pkg::ST_P9)
					state_d = bsc_pkg::S_OUT;
				else if (step_q == bsc_pkg::ST_P5 && v1n == '0)
					state_d = bsc_pkg::S_OUT;
				else if (step_q == bsc_pkg::ST_P6)
					state_d = bsc_pkg::S_DIV;
				else
					state_d = bsc_pkg::S_LOAD;
			end
			bsc_pkg::S_DIV: if (last) state_d = bsc_pkg::S_DIVPOST;
			bsc_pkg::S_DIVPOST: state_d = bsc_pkg::S_LOAD;
			bsc_pkg::S_OUT: if (out_free) state_d = bsc_pkg::S_IDLE;
			default: state_d = bsc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal0_q <= '0;
			cal1_q <= '0;
			cal2_q <= '0;
			cal3_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bsc_pkg::RegTemp:   cal0_q <= cfg_data;
				bsc_pkg::RegPressA: cal1_q <= cfg_data;
				bsc_pkg::RegPressB: cal2_q <= cfg_data;
				bsc_pkg::RegPressC: cal3_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q    <= '0;
			ovld_q  <= 1'b0;
			step_q  <= bsc_pkg::ST_T0;
			cnt_q   <= '0;
		end else begin
			ovld_q <= (state_q == bsc_pkg::S_OUT && out_free) || (ovld_q && !result.ready);
			case (state_q)
				bsc_pkg::S_IDLE: if (take) begin
					kind_q <= sample.kind;
					adc_q  <= sample.raw_sample;
					zero_q <= 1'b0;
					step_q <= sample.kind ? bsc_pkg::ST_P0 : bsc_pkg::ST_T0;
				end
				bsc_pkg::S_LOAD: begin
					ma_q  <= opa;
					mb_q  <= opb;
					acc_q <= '0;
					cnt_q <= '0;
				end
				bsc_pkg::S_MUL: begin
					if (mb_q[0]) acc_q <= acc_q + ma_q;
					ma_q  <= ma_q << 1;
					mb_q  <= mb_q >> 1;
					cnt_q <= cnt_q + 1'b1;
				end
				bsc_pkg::S_POST: begin
					step_q <= bsc_pkg::step_t'(step_q + 1'b1);
					case (step_q)
						bsc_pkg::ST_T0: v1_q <= bsc_pkg::asr(acc_q, 5'd11);
						bsc_pkg::ST_T1: q_q <= bsc_pkg::asr(acc_q, 5'd12);
						bsc_pkg::ST_T2: ft_q <= v1_q + bsc_pkg::asr(acc_q, 5'd14);
						bsc_pkg::ST_T3:
							fin_q <= bsc_pkg::asr(acc_q + bsc_pkg::RoundHalf, 5'd8);
						bsc_pkg::ST_P0: begin q_q <= acc_q; v1_q <= vv; end
						bsc_pkg::ST_P1: v2_q <= acc_q;
						bsc_pkg::ST_P2: v2_q <= bsc_pkg::asr(v2_q + (acc_q << 1), 5'd2)
							+ (p4 << 16);
						bsc_pkg::ST_P3: q_q <= bsc_pkg::asr(acc_q, 5'd3);
						bsc_pkg::ST_P4: v1_q <= bsc_pkg::asr(q_q
							+ bsc_pkg::asr(acc_q, 5'd1), 5'd18);
						bsc_pkg::ST_P5: begin
							v1_q <= v1n;
							if (v1n == '0) begin
								zero_q <= 1'b1;
								fin_q  <= '0;
							end
						end
						bsc_pkg::ST_P6: begin
							p_q   <= acc_q;
							num_q <= acc_q[W-1] ? acc_q : (acc_q << 1);
							rem_q <= '0;
							cnt_q <= '0;
						end
						bsc_pkg::ST_P7: q_q <= acc_q >> 13;
						bsc_pkg::ST_P8: v1_q <= bsc_pkg::asr(acc_q, 5'd12);
						bsc_pkg::ST_P9: fin_q <= p_q + bsc_pkg::asr(v1_q
							+ bsc_pkg::asr(acc_q, 5'd13) + p7, 5'd4);
						default: ;
					endcase
				end
				bsc_pkg::S_DIV: begin
					if (!trial[W+1]) rem_q <= trial[W-1:0];
					else rem_q <= {rem_q[W-2:0], num_q[W-1]};
					num_q <= {num_q[W-2:0], !trial[W+1]};
					cnt_q <= cnt_q + 1'b1;
				end
				bsc_pkg::S_DIVPOST: p_q <= p_q[W-1] ? (num_q << 1) : num_q;
				bsc_pkg::S_OUT: if (out_free) begin
					okind_q  <= kind_q;
					otemp_q  <= kind_q ? '0 : fin_q;
					opress_q <= kind_q ? fin_q : '0;
					ozero_q  <= zero_q;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> tb/sv/bsc_checker.sv
`timescale 1ns / 1ps
// Checker for the barometric sensor compensation block: watches the calibration port
// and both channels, predicts each result and compares it field by field.
// Depends on bsc_pkg, bsc_sample_if and bsc_result_if.
module bsc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bsc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bsc_pkg::CalW-1:0]      cfg_data,
	bsc_sample_if                         smp,
	bsc_result_if                         res,
	output int                            errors,
	output int                            pending
);
	typedef struct packed {
		logic        kind;
		logic [31:0] temp;
		logic [31:0] press;
		logic        zero;
	} reading_t;

	logic [bsc_pkg::CalW-1:0] cal [4];
	logic [31:0]              fine_t;
	reading_t                 expected_q [$];

	function automatic logic [31:0] sra(logic [31:0] x, int unsigned s);
		return $signed(x) >>> s;
	endfunction

	function automatic logic [31:0] sext(logic [15:0] w);
		return {{16{w[15]}}, w};
	endfunction

	function automatic logic [31:0] comp_temp(logic [19:0] raw);
		logic [31:0] adc, t1, t2, t3, a, d, b, m;
		adc = {12'b0, raw};
		t1 = {16'b0, cal[bsc_pkg::RegTemp][15:0]};
		t2 = sext(cal[bsc_pkg::RegTemp][31:16]);
		t3 = sext(cal[bsc_pkg::RegTemp][47:32]);
		m = (adc >> 3) - (t1 << 1);
		m = m * t2;
		a = sra(m, 11);
		d = (adc >> 4) - t1;
		m = d * d;
		m = sra(m, 12);
		m = m * t3;
		b = sra(m, 14);
		fine_t = a + b;
		m = fine_t * 32'd5 + 32'd128;
		return sra(m, 8);
	endfunction

	function automatic logic [31:0] comp_press(logic [19:0] raw, output logic zero);
		logic [31:0] adc, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] v1, v2, q, p, m, n;
		adc = {12'b0, raw};
		p1 = {16'b0, cal[bsc_pkg::RegPressA][15:0]};
		p2 = sext(cal[bsc_pkg::RegPressA][31:16]);
		p3 = sext(cal[bsc_pkg::RegPressA][47:32]);
		p4 = sext(cal[bsc_pkg::RegPressB][15:0]);
		p5 = sext(cal[bsc_pkg::RegPressB][31:16]);
		p6 = sext(cal[bsc_pkg::RegPressB][47:32]);
		p7 = sext(cal[bsc_pkg::RegPressC][15:0]);
		p8 = sext(cal[bsc_pkg::RegPressC][31:16]);
		p9 = sext(cal[bsc_pkg::RegPressC][47:32]);
		v1 = sra(fine_t, 1) - 32'd64000;
		m = sra(v1, 2);
		q = m * m;
		m = sra(q, 11);
		v2 = m * p6;
		m = v1 * p5;
		m = m << 1;
		v2 = v2 + m;
		m = p4 << 16;
		v2 = sra(v2, 2) + m;
		m = sra(q, 13);
		m = p3 * m;
		n = p2 * v1;
		m = sra(m, 3) + sra(n, 1);
		v1 = sra(m, 18);
		m = 32'd32768 + v1;
		m = m * p1;
		v1 = sra(m, 15);
		if (v1 == 0) begin
			zero = 1'b1;
			return 32'd0;
		end
		zero = 1'b0;
		m = (32'd1048576 - adc) - sra(v2, 12);
		p = m * 32'd3125;
		if (p < 32'h8000_0000) begin
			m = p << 1;
			p = m / v1;
		end else begin
			m = p / v1;
			p = m * 32'd2;
		end
		m = p >> 3;
		m = m * m;
		m = m >> 13;
		m = p9 * m;
		v1 = sra(m, 12);
		m = p >> 2;
		m = m * p8;
		v2 = sra(m, 13);
		m = v1 + v2 + p7;
		return p + sra(m, 4);
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		reading_t e, got;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				cal[i] = '0;
			fine_t = '0;
			errors = 0;
			expected_q.delete();
		end else begin
			if (cfg_we && cfg_index < 4)
				cal[cfg_index[1:0]] = cfg_data;
			if (smp.valid && smp.ready) begin
				e = '0;
				e.kind = smp.kind;
				if (smp.kind == 1'b0)
					e.temp = comp_temp(smp.raw_sample);
				else
					e.press = comp_press(smp.raw_sample, e.zero);
				expected_q.push_back(e);
			end
			if (res.valid && res.ready) begin
				got = {res.result_kind, res.temperature_centi, res.pressure_pa,
					res.zero_divisor};
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, actual %h", $time, got);
				end else begin
					e = expected_q.pop_front();
					if (got.kind !== e.kind) begin
						errors++;
						$display("%0t: result_kind expected %0d actual %0d",
							$time, e.kind, got.kind);
					end
					if (got.temp !== e.temp) begin
						errors++;
						$display("%0t: temperature_centi expected %0d actual %0d",
							$time, $signed(e.temp), $signed(got.temp));
					end
					if (got.press !== e.press) begin
						errors++;
						$display("%0t: pressure_pa expected %0d actual %0d",
							$time, e.press, got.press);
					end
					if (got.zero !== e.zero) begin
						errors++;
						$display("%0t: zero_divisor expected %0d actual %0d",
							$time, e.zero, got.zero);
					end
				end
			end
		end
	end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the compensation testbench: clock, reset, calibration phases and sample stimulus.
// Depends on bsc_pkg, the channel interfaces, bsc_checker and the block itself.
module tb;
	localparam int StallLimit = 20000;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [bsc_pkg::CfgIdxW-1:0] cfg_index;
	logic [bsc_pkg::CalW-1:0]    cfg_data;
	logic                        calm;
	int                          errors;
	int                          pending;
	int                          stall_cnt;

	bsc_sample_if smp();
	bsc_result_if res();

	barometric_sensor_compensation dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .sample(smp), .result(res)
	);

	bsc_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .smp(smp), .res(res), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		res.ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);

	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= StallLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [bsc_pkg::CalW-1:0] rand_cal();
		return {16'($urandom), 32'($urandom)};
	endfunction

	task automatic set_cal(logic [bsc_pkg::CalW-1:0] t, logic [bsc_pkg::CalW-1:0] a,
		logic [bsc_pkg::CalW-1:0] b, logic [bsc_pkg::CalW-1:0] c);
		cfg_we <= 1'b1;
		cfg_index <= bsc_pkg::RegTemp;
		cfg_data <= t;
		@(posedge clk);
		cfg_index <= bsc_pkg::RegPressA;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= bsc_pkg::RegPressB;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= bsc_pkg::RegPressC;
		cfg_data <= c;
		@(posedge clk);
		// out-of-range index must leave every register alone
		cfg_index <= bsc_pkg::CfgIdxW'($urandom_range(255, 4));
		cfg_data <= rand_cal();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send(logic kind, logic [bsc_pkg::RawW-1:0] raw);
		smp.valid <= 1'b1;
		smp.kind <= kind;
		smp.raw_sample <= raw;
		do
			@(posedge clk);
		while (!smp.ready);
		if (!calm && $urandom_range(99) < 11) begin
			smp.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic run_random(int count, bit realistic);
		logic                     kind;
		logic [bsc_pkg::RawW-1:0] raw;
		int                       pick;
		for (int i = 0; i < count; i++) begin
			calm = (i >= count / 3 && i < count / 3 + 150);
			kind = ($urandom_range(99) < 60);
			pick = $urandom_range(99);
			if (pick < 5)
				raw = pick[0] ? '1 : '0;
			else if (realistic && pick < 75)
				raw = kind ? 20'($urandom_range(480000, 250000))
					: 20'($urandom_range(560000, 470000));
			else
				raw = 20'($urandom);
			send(kind, raw);
		end
		calm = 1'b0;
		drain();
	endtask

	localparam logic [bsc_pkg::CalW-1:0] TypT = {16'hFC18, 16'd26435, 16'd27504};
	localparam logic [bsc_pkg::CalW-1:0] TypA = {16'd3024, 16'hD643, 16'd36477};
	localparam logic [bsc_pkg::CalW-1:0] TypB = {16'hFFF9, 16'd140, 16'd2855};
	localparam logic [bsc_pkg::CalW-1:0] TypC = {16'd6000, 16'hC6F8, 16'd15500};
	localparam logic [bsc_pkg::CalW-1:0] NoP1 = {{(bsc_pkg::CalW - 16){1'b1}}, 16'd0};

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		stall_cnt = 0;
		smp.valid = 1'b0;
		smp.kind = 1'b0;
		smp.raw_sample = '0;
		res.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero calibration: pressure before any temperature, zero divisor
		send(1'b1, 20'd415148);
		send(1'b0, '0);
		send(1'b0, '1);
		send(1'b1, '0);
		send(1'b1, '1);
		drain();

		set_cal(TypT, TypA, TypB, TypC);
		send(1'b1, 20'd415148);
		send(1'b0, 20'd519888);
		send(1'b1, 20'd415148);
		send(1'b0, '0);
		send(1'b1, '0);
		send(1'b1, '1);
		send(1'b0, '1);
		send(1'b1, 20'd300000);
		drain();

		set_cal('1, '1, '1, '1);
		send(1'b0, '0);
		send(1'b1, '1);
		send(1'b0, '1);
		send(1'b1, '0);
		drain();

		set_cal(TypT, TypA, TypB, TypC);
		run_random(700, 1'b1);
		set_cal(rand_cal(), rand_cal(), rand_cal(), rand_cal());
		run_random(250, 1'b1);
		set_cal(rand_cal(), rand_cal(), rand_cal(), rand_cal());
		run_random(250, 1'b0);
		set_cal(rand_cal(), rand_cal() & NoP1, rand_cal(), rand_cal());
		run_random(150, 1'b0);
		set_cal(rand_cal(), TypA, TypB, TypC);
		run_random(150, 1'b1);
		set_cal('1, '1, '1, '1);
		run_random(100, 1'b0);
		set_cal('0, '0, '0, '0);
		run_random(100, 1'b0);

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
